// ===== design/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and constants for the 32-bit integer ALU with carry flags.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned OpW   = 5;
  localparam int unsigned ShW   = 6;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_PASS  = 5'd0,
    OP_AND   = 5'd1,
    OP_ANDC  = 5'd2,
    OP_CMP   = 5'd3,
    OP_CMPL  = 5'd4,
    OP_CLZ   = 5'd5,
    OP_EXTSB = 5'd6,
    OP_EXTSH = 5'd7,
    OP_ADDNF = 5'd8,
    OP_NAND  = 5'd9,
    OP_NOR   = 5'd10,
    OP_OR    = 5'd11,
    OP_ORC   = 5'd12,
    OP_SLL   = 5'd13,
    OP_SRA   = 5'd14,
    OP_SRL   = 5'd15,
    OP_XOR   = 5'd16,
    OP_ADD   = 5'd17,
    OP_ADDE  = 5'd18,
    OP_SUBF  = 5'd19,
    OP_SUBFE = 5'd20
  } op_e;

  // Compare result codes
  localparam logic [WordW-1:0] CmpLt = 32'd4;
  localparam logic [WordW-1:0] CmpGt = 32'd2;
  localparam logic [WordW-1:0] CmpEq = 32'd1;

  // One operation as it enters the datapath
  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic             carry_in;
  } ialu_op_t;

  // One result with its flags
  typedef struct packed {
    logic [WordW-1:0] result;
    logic             carry_out;
    logic             overflow;
    logic             decode_error;
  } ialu_res_t;

endpackage

// ===== design/ialu_in_if.sv =====
// ----------------------------------------------------------------------------
// ialu_in_if
// Operation channel: valid/ready handshake with opcode, operands and carry.
// ----------------------------------------------------------------------------
interface ialu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  operation;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        carry_in;

  modport source (output valid, output operation, output operand_a,
                  output operand_b, output carry_in, input ready);
  modport sink   (input valid, input operation, input operand_a,
                  input operand_b, input carry_in, output ready);
endinterface

// ===== design/ialu_out_if.sv =====
// ----------------------------------------------------------------------------
// ialu_out_if
// Result channel: valid/ready handshake with result and flags.
// ----------------------------------------------------------------------------
interface ialu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        carry_out;
  logic        overflow;
  logic        decode_error;

  modport source (output valid, output result, output carry_out,
                  output overflow, output decode_error, input ready);
  modport sink   (input valid, input result, input carry_out,
                  input overflow, input decode_error, output ready);
endinterface

// ===== design/ialu_core.sv =====
// ----------------------------------------------------------------------------
// ialu_core
// Combinational datapath: logic ops, compares, count leading zeros, sign
// extension, shifts and one shared 33-bit adder for add and subtract-from.
// ----------------------------------------------------------------------------
module ialu_core (
  input  ialu_pkg::ialu_op_t  op_i,
  output ialu_pkg::ialu_res_t res_o
);
  import ialu_pkg::*;

  logic [WordW-1:0] a, b;
  logic [ShW-1:0]   sh;
  logic [WordW-1:0] add_x;
  logic             add_c;
  logic [WordW:0]   sum;
  logic             add_ovf;
  logic [WordW-1:0] clz_v;
  logic [ShW-1:0]   clz_n;
  logic [WordW-1:0] cmp_s, cmp_u;
  logic [WordW-1:0] sll_r, srl_r, sra_r;

  assign a  = op_i.operand_a;
  assign b  = op_i.operand_b;
  assign sh = b[ShW-1:0];

  // Shared adder: subtract-from inverts a, carry-in chosen by opcode
  always_comb begin
    add_x = a;
    add_c = 1'b0;
    case (op_i.operation)
      OP_ADDE:  add_c = op_i.carry_in;
      OP_SUBF: begin
        add_x = ~a;
        add_c = 1'b1;
      end
      OP_SUBFE: begin
        add_x = ~a;
        add_c = op_i.carry_in;
      end
      default: begin
        add_x = a;
        add_c = 1'b0;
      end
    endcase
  end

  assign sum     = {1'b0, add_x} + {1'b0, b} + {{WordW{1'b0}}, add_c};
  assign add_ovf = ~(add_x[WordW-1] ^ b[WordW-1]) & (add_x[WordW-1] ^ sum[WordW-1]);

  // Count leading zeros by halving search, five steps
  always_comb begin
    clz_v = a;
    clz_n = '0;
    if (clz_v[31:16] == '0) begin
      clz_n = clz_n + 6'd16;
      clz_v = clz_v << 16;
    end
    if (clz_v[31:24] == '0) begin
      clz_n = clz_n + 6'd8;
      clz_v = clz_v << 8;
    end
    if (clz_v[31:28] == '0) begin
      clz_n = clz_n + 6'd4;
      clz_v = clz_v << 4;
    end
    if (clz_v[31:30] == '0) begin
      clz_n = clz_n + 6'd2;
      clz_v = clz_v << 2;
    end
    if (clz_v[31] == 1'b0) begin
      clz_n = clz_n + 6'd1;
      // a zero operand still has bit 31 clear after the last step
      if (clz_v[30] == 1'b0) begin
        clz_n = clz_n + 6'd1;
      end
    end
  end

  // Compares
  assign cmp_s = ($signed(a) < $signed(b)) ? CmpLt :
                 (($signed(a) > $signed(b)) ? CmpGt : CmpEq);
  assign cmp_u = (a < b) ? CmpLt : ((a > b) ? CmpGt : CmpEq);

  // Shifts: amounts of 32 or more fill
  assign sll_r = sh[ShW-1] ? '0 : (a << sh[ShW-2:0]);
  assign srl_r = sh[ShW-1] ? '0 : (a >> sh[ShW-2:0]);
  assign sra_r = sh[ShW-1] ? {WordW{a[WordW-1]}}
                           : WordW'($signed(a) >>> sh[ShW-2:0]);

  // Result select
  always_comb begin
    res_o.result       = '0;
    res_o.carry_out    = 1'b0;
    res_o.overflow     = 1'b0;
    res_o.decode_error = 1'b0;
    case (op_i.operation)
      OP_PASS:  res_o.result = a;
      OP_AND:   res_o.result = a & b;
      OP_ANDC:  res_o.result = a & ~b;
      OP_CMP:   res_o.result = cmp_s;
      OP_CMPL:  res_o.result = cmp_u;
      OP_CLZ:   res_o.result = {{(WordW-ShW){1'b0}}, clz_n};
      OP_EXTSB: res_o.result = {{24{a[7]}}, a[7:0]};
      OP_EXTSH: res_o.result = {{16{a[15]}}, a[15:0]};
      OP_ADDNF: res_o.result = sum[WordW-1:0];
      OP_NAND:  res_o.result = ~(a & b);
      OP_NOR:   res_o.result = ~(a | b);
      OP_OR:    res_o.result = a | b;
      OP_ORC:   res_o.result = a | ~b;
      OP_SLL:   res_o.result = sll_r;
      OP_SRA:   res_o.result = sra_r;
      OP_SRL:   res_o.result = srl_r;
      OP_XOR:   res_o.result = a ^ b;
      OP_ADD, OP_ADDE, OP_SUBF, OP_SUBFE: begin
        res_o.result    = sum[WordW-1:0];
        res_o.carry_out = sum[WordW];
        res_o.overflow  = add_ovf;
      end
      default: begin
        res_o.result       = '1;
        res_o.decode_error = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/integer_alu_with_carry_flags_top.sv =====
// ----------------------------------------------------------------------------
// integer_alu_with_carry_flags_top
// 32-bit integer ALU: input register, one combinational pass, result register.
// ----------------------------------------------------------------------------
//
//  channel  | port  | direction | carries
//  ---------+-------+-----------+--------------------------------------------
//  input    | in_i  | sink      | operation, operand_a, operand_b, carry_in
//  output   | out_o | source    | result, carry_out, overflow, decode_error
//
// One item per cycle sustained while out_o stays ready; a result reaches out_o
// after transfer on in_i through the input register, then the result register.
// Each item makes a single pass through the shared adder and selector.
// Reset clears both stage valid bits; payload registers are not reset.
// A stall on out_o holds the result register; the input stage keeps
// accepting while it is empty or moving forward.
// ----------------------------------------------------------------------------
module integer_alu_with_carry_flags_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ialu_in_if.sink    in_i,
  ialu_out_if.source out_o
);
  import ialu_pkg::*;

  logic      s1_valid_q;
  ialu_op_t  s1_q;
  logic      s2_valid_q;
  ialu_res_t s2_q;
  ialu_res_t res;
  logic      s1_adv;
  logic      in_xfer;

  // Advance when the result stage is free or drains this cycle
  assign s1_adv  = !s2_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer = in_i.valid && in_i.ready;

  ialu_core u_core (
    .op_i  (s1_q),
    .res_o (res)
  );

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q.operation <= in_i.operation;
      s1_q.operand_a <= in_i.operand_a;
      s1_q.operand_b <= in_i.operand_b;
      s1_q.carry_in  <= in_i.carry_in;
    end
    if (s1_adv && s1_valid_q) begin
      s2_q <= res;
    end
  end

  // Drive result channel
  assign out_o.valid        = s2_valid_q;
  assign out_o.result       = s2_q.result;
  assign out_o.carry_out    = s2_q.carry_out;
  assign out_o.overflow     = s2_q.overflow;
  assign out_o.decode_error = s2_q.decode_error;

`ifndef SYNTHESIS
  // An accepted transfer occupies the input stage next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("accepted item did not reach input stage");

  // Flags come only from add and subtract-from operations
  a_flags_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (res.carry_out || res.overflow)) |->
      (s1_q.operation == OP_ADD || s1_q.operation == OP_ADDE ||
       s1_q.operation == OP_SUBF || s1_q.operation == OP_SUBFE))
    else $error("carry or overflow from a non-arithmetic operation");

  // A decode error delivers all ones with both flags clear
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_q.decode_error) |->
      (s2_q.result == '1 && !s2_q.carry_out && !s2_q.overflow))
    else $error("decode error with wrong result or flags");

  // A held result is not overwritten while stalled
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_o.ready) |=> (s2_valid_q && $stable(s2_q)))
    else $error("result register changed during stall");
`endif

endmodule

// ===== tb/tb_integer_alu_with_carry_flags_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_alu_with_carry_flags_top
// Streams operations into the ALU through its valid/ready input channel and
// checks every result and flag against a predictor in this file, in order.
// Both channels pause at random, with calm stretches in between. A directed
// set covers each operation and the corner cases. Random operations with
// corner-heavy operands and occasional invalid codes follow.
// ----------------------------------------------------------------------------
module tb_integer_alu_with_carry_flags_top;
  import ialu_pkg::*;

  // One pending operation and the cycles the source waits before offering it
  typedef struct {
    ialu_op_t    op;
    int unsigned gap;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ialu_in_if  in_if ();
  ialu_out_if out_if ();

  integer_alu_with_carry_flags_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  stim_t       stim_q[$];
  ialu_res_t   alu_expect_q[$];
  int unsigned err_count = 0;

  // Source side state
  stim_t       cur_stim;
  bit          holding = 1'b0;
  int unsigned gap_left = 0;
  int unsigned src_run = 0;
  bit          src_calm = 1'b0;

  // Sink side state
  ialu_res_t   want;
  int unsigned sink_hold = 0;
  int unsigned sink_run = 0;
  bit          sink_calm = 1'b0;

  // Toggle the clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Compute the result and flags of one operation
  function automatic ialu_res_t alu_eval(ialu_op_t t);
    ialu_res_t   r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] x;
    logic [32:0] wide;
    logic [5:0]  sh;
    logic        cin;
    bit          arith;
    a     = t.operand_a;
    b     = t.operand_b;
    sh    = b[5:0];
    x     = '0;
    cin   = 1'b0;
    arith = 1'b0;
    r     = '0;
    case (t.operation)
      OP_PASS:  r.result = a;
      OP_AND:   r.result = a & b;
      OP_ANDC:  r.result = a & ~b;
      OP_CMP: begin
        if ($signed(a) < $signed(b))      r.result = CmpLt;
        else if ($signed(a) > $signed(b)) r.result = CmpGt;
        else                              r.result = CmpEq;
      end
      OP_CMPL: begin
        if (a < b)      r.result = CmpLt;
        else if (a > b) r.result = CmpGt;
        else            r.result = CmpEq;
      end
      OP_CLZ: begin
        // The highest set bit is found last
        r.result = 32'd32;
        for (int i = 0; i < 32; i++) begin
          if (a[i]) r.result = 32'(31 - i);
        end
      end
      OP_EXTSB: r.result = {{24{a[7]}}, a[7:0]};
      OP_EXTSH: r.result = {{16{a[15]}}, a[15:0]};
      OP_ADDNF: r.result = a + b;
      OP_NAND:  r.result = ~(a & b);
      OP_NOR:   r.result = ~(a | b);
      OP_OR:    r.result = a | b;
      OP_ORC:   r.result = a | ~b;
      OP_SLL:   r.result = sh[5] ? '0 : a << sh[4:0];
      OP_SRA: begin
        // Keep the shift in its own statement so it stays arithmetic
        if (sh[5]) r.result = {32{a[31]}};
        else       r.result = $signed(a) >>> sh[4:0];
      end
      OP_SRL:   r.result = sh[5] ? '0 : a >> sh[4:0];
      OP_XOR:   r.result = a ^ b;
      OP_ADD: begin
        x = a;  cin = 1'b0;        arith = 1'b1;
      end
      OP_ADDE: begin
        x = a;  cin = t.carry_in;  arith = 1'b1;
      end
      OP_SUBF: begin
        x = ~a; cin = 1'b1;        arith = 1'b1;
      end
      OP_SUBFE: begin
        x = ~a; cin = t.carry_in;  arith = 1'b1;
      end
      default: begin
        r.result       = '1;
        r.decode_error = 1'b1;
      end
    endcase
    // Flagged add: carry out of bit 31, overflow when like signs give unlike sum
    if (arith) begin
      wide        = {1'b0, x} + {1'b0, b} + {32'd0, cin};
      r.result    = wide[31:0];
      r.carry_out = wide[32];
      r.overflow  = (x[31] == b[31]) && (wide[31] != x[31]);
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    err_count++;
  endtask

  // Queue one operation, drawing the source pause in calm or busy stretches
  task automatic push_item(logic [4:0] op, logic [31:0] a, logic [31:0] b, logic cin);
    stim_t s;
    if (src_run == 0) begin
      src_run  = $urandom_range(10, 60);
      src_calm = ($urandom_range(0, 3) == 0);
    end
    src_run--;
    s.op.operation = op;
    s.op.operand_a = a;
    s.op.operand_b = b;
    s.op.carry_in  = cin;
    s.gap          = src_calm ? 0 : $urandom_range(0, 13);
    stim_q.push_back(s);
  endtask

  // Draw an operand, leaning on the corners
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'($urandom_range(0, 70));
      5:       return 32'h1 << $urandom_range(0, 31);
      6:       return $urandom() | 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Drive known values before the first edge
  initial begin
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.operation     = '0;
    in_if.operand_a     = '0;
    in_if.operand_b     = '0;
    in_if.carry_in      = 1'b0;
    out_if.ready        = 1'b0;
  end

  // Source: offer the head item after its pause and hold it until transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        alu_expect_q.push_back(alu_eval(cur_stim.op));
        holding = 1'b0;
      end
      if (!holding && stim_q.size() != 0) begin
        cur_stim = stim_q.pop_front();
        gap_left = cur_stim.gap;
        holding  = 1'b1;
      end
      if (holding && gap_left == 0) begin
        in_if.valid     <= 1'b1;
        in_if.operation <= cur_stim.op.operation;
        in_if.operand_a <= cur_stim.op.operand_a;
        in_if.operand_b <= cur_stim.op.operand_b;
        in_if.carry_in  <= cur_stim.op.carry_in;
      end else begin
        in_if.valid <= 1'b0;
        if (holding) gap_left--;
      end
    end
  end

  // Sink: check each transfer against the oldest expectation, then stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (alu_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", out_if.result));
        end else begin
          want = alu_expect_q.pop_front();
          if (out_if.result !== want.result)
            report_mismatch($sformatf("result got %h expected %h",
                                      out_if.result, want.result));
          if (out_if.carry_out !== want.carry_out)
            report_mismatch($sformatf("carry_out got %b expected %b",
                                      out_if.carry_out, want.carry_out));
          if (out_if.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %b expected %b",
                                      out_if.overflow, want.overflow));
          if (out_if.decode_error !== want.decode_error)
            report_mismatch($sformatf("decode_error got %b expected %b",
                                      out_if.decode_error, want.decode_error));
        end
        if (sink_run == 0) begin
          sink_run  = $urandom_range(10, 60);
          sink_calm = ($urandom_range(0, 3) == 0);
        end
        sink_run--;
        sink_hold = sink_calm ? 0 : $urandom_range(0, 13);
      end else if (sink_hold != 0) begin
        sink_hold--;
      end
      out_if.ready <= (sink_hold == 0);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [4:0]  op;
    logic [31:0] a;
    logic [31:0] b;

    // Directed: every operation, operand extremes and the special cases
    push_item(OP_PASS,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    push_item(OP_AND,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_item(OP_ANDC,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    push_item(OP_CMP,   32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_item(OP_CMP,   32'h8000_0000, 32'h8000_0000, 1'b0);
    push_item(OP_CMPL,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    push_item(OP_CLZ,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    push_item(OP_CLZ,   32'h8000_0000, 32'h0000_0000, 1'b0);
    push_item(OP_EXTSB, 32'h0000_0080, 32'h0000_0000, 1'b0);
    push_item(OP_EXTSH, 32'hFFFF_7FFF, 32'h0000_0000, 1'b0);
    push_item(OP_ADDNF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    push_item(OP_NAND,  32'h0000_0000, 32'h0000_0000, 1'b0);
    push_item(OP_NOR,   32'h0000_0000, 32'h0000_0000, 1'b0);
    push_item(OP_OR,    32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    push_item(OP_ORC,   32'h0000_0000, 32'h0000_0000, 1'b0);
    push_item(OP_SLL,   32'h0000_0001, 32'h0000_001F, 1'b0);
    // Shift amounts of 32 or more, upper bits of the amount ignored
    push_item(OP_SLL,   32'hFFFF_FFFF, 32'h0000_0020, 1'b0);
    push_item(OP_SRA,   32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    push_item(OP_SRA,   32'h8000_0001, 32'h0000_0040, 1'b0);
    push_item(OP_SRL,   32'hFFFF_FFFF, 32'hFFFF_FFE1, 1'b0);
    push_item(OP_XOR,   32'hFFFF_FFFF, 32'h0F0F_F0F0, 1'b0);
    // Signed overflow, carry from carry-in, subtract flags
    push_item(OP_ADD,   32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
    push_item(OP_ADDE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    push_item(OP_SUBF,  32'h0000_0000, 32'h0000_0000, 1'b0);
    push_item(OP_SUBFE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_item(5'd21,    32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    push_item(5'd31,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0);

    // Random: mostly valid codes, some invalid ones, corner-heavy operands
    for (int n = 0; n < 1625; n++) begin
      if ($urandom_range(0, 11) == 0) op = 5'($urandom_range(21, 31));
      else                            op = 5'($urandom_range(0, 20));
      a = pick_word();
      b = ($urandom_range(0, 7) == 0) ? a : pick_word();
      push_item(op, a, b, 1'($urandom_range(0, 1)));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Let the source drain, then every expected result arrive
    while (stim_q.size() != 0 || holding) @(posedge clk_i);
    while (alu_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (err_count == 0) begin
      $display("integer_alu_with_carry_flags_top verification clean");
    end else begin
      $display("integer_alu_with_carry_flags_top verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("integer_alu_with_carry_flags_top verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/ialu_pkg.sv
design/ialu_in_if.sv
design/ialu_out_if.sv
design/ialu_core.sv
design/integer_alu_with_carry_flags_top.sv
tb/tb_integer_alu_with_carry_flags_top.sv
